@@ rtl/core/receive_dc_remove_flip_peak_macros.svh @@
// Assertion macros shared by the receive conditioner RTL.
`ifndef RECEIVE_DC_REMOVE_FLIP_PEAK_MACROS_SVH
`define RECEIVE_DC_REMOVE_FLIP_PEAK_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off during reset.
`define RDFP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RDFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RDFP_ASSERT_SAME(lbl, ante, cons, msg)
`define RDFP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/rdcfp_pkg.sv @@
// Shared widths, reset values and register indexes of the receive conditioner.
package rdcfp_pkg;

    localparam int SAMPLE_W             = 16;
    localparam int CLEAN_W              = 25;
    localparam int PEAK_W               = 24;
    localparam int BLEN_W               = 13;
    localparam int CFG_W                = 13;
    localparam int CFG_IDX_W            = 2;
    localparam int FRAC_W               = 8;
    localparam int MEAN_W               = 24;
    localparam int DC_BLOCKS_DEF        = 32;
    localparam int MAX_BLOCK_LENGTH_DEF = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_ENABLE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SELECT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_ENABLE    = 2'd3;

    localparam logic [BLEN_W-1:0] BLEN_RESET = 13'd1280;

endpackage

@@ rtl/core/receive_dc_remove_flip_peak.sv @@
// Receive conditioner top level: mix, block-mean DC removal, flip, block peak.
// Path: an accepted beat moves through the input registers, y_raw_reg and the output
//   register; it waits in S_SHAPE while the output register holds an unaccepted beat.
// Flow: a new sample is accepted only in S_IDLE, once the last one has left S_SHAPE;
//   a block-end sample first runs the serial block-mean division, the ring update and
//   a reciprocal multiply for the DC estimate before the next sample is taken.
// Reset: asynchronous, clears the control state; the DC ring reads as zero through
//   per-entry valid bits, so no clearing pass is needed.
`include "receive_dc_remove_flip_peak_macros.svh"

module receive_dc_remove_flip_peak #(
    parameter int DC_BLOCKS        = rdcfp_pkg::DC_BLOCKS_DEF,
    parameter int MAX_BLOCK_LENGTH = rdcfp_pkg::MAX_BLOCK_LENGTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [rdcfp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rdcfp_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [rdcfp_pkg::SAMPLE_W-1:0]  left_sample,
    input  logic signed [rdcfp_pkg::SAMPLE_W-1:0]  right_sample,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [rdcfp_pkg::CLEAN_W-1:0]   clean_sample,
    output logic                                   block_end,
    output logic [rdcfp_pkg::PEAK_W-1:0]           peak_level
);

    import rdcfp_pkg::*;

    localparam int CNT_W   = $clog2(MAX_BLOCK_LENGTH);
    localparam int LEN_W   = (BLEN_W > CNT_W + 1) ? BLEN_W : CNT_W + 1;
    localparam int ACC_W   = SAMPLE_W + 1 + CNT_W;
    localparam int RP_W    = $clog2(DC_BLOCKS);
    localparam int RT_W    = MEAN_W + RP_W;
    localparam int NUM_M_W = ACC_W + FRAC_W;
    localparam int DVD_W   = (NUM_M_W > RT_W) ? NUM_M_W : RT_W;
    localparam int DVS_A   = $clog2(MAX_BLOCK_LENGTH + 1);
    localparam int DVS_B   = $clog2(DC_BLOCKS + 1);
    localparam int DVS_W   = (DVS_A > DVS_B) ? DVS_A : DVS_B;
    localparam int DCNT_W  = $clog2(DVD_W + 1);
    localparam int Y_W     = CLEAN_W + 1;
    localparam int DC_SHIFT = RT_W + RP_W;
    localparam int RCP_W    = RT_W + 1;
    localparam int PROD_W   = RT_W + RCP_W;
    localparam logic [RCP_W-1:0] DC_RECIP =
        RCP_W'(((longint'(1) << DC_SHIFT) + longint'(DC_BLOCKS - 1)) / longint'(DC_BLOCKS));

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_MIX   = 8'b00000010,
        S_SHAPE = 8'b00000100,
        S_DIVM  = 8'b00001000,
        S_RSUB  = 8'b00010000,
        S_RADD  = 8'b00100000,
        S_DCLD  = 8'b01000000,
        S_DCSET = 8'b10000000
    } state_t;

    // control state
    state_t                    state_reg, state_next;
    logic [BLEN_W-1:0]         blen_reg, blen_next;
    logic                      mix_reg, mix_next;
    logic                      chsel_reg, chsel_next;
    logic                      flip_reg, flip_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [RP_W-1:0]           ring_pos_reg, ring_pos_next;
    logic signed [RT_W-1:0]    ring_total_reg, ring_total_next;
    logic signed [MEAN_W-1:0]  dc_reg, dc_next;
    logic                      phase_reg, phase_next;
    logic [PEAK_W-1:0]         peak_reg, peak_next;
    logic [DC_BLOCKS-1:0]      ring_valid_reg, ring_valid_next;
    logic                      out_valid_reg, out_valid_next;

    // payload state
    logic signed [SAMPLE_W-1:0] left_reg, left_next;
    logic signed [SAMPLE_W-1:0] right_reg, right_next;
    logic signed [Y_W-1:0]      y_raw_reg, y_raw_next;
    logic signed [MEAN_W-1:0]   mean_reg, mean_next;
    logic [DVD_W-1:0]           num_reg, num_next;
    logic [DVS_W-1:0]           rem_reg, rem_next;
    logic [DVS_W-1:0]           den_reg, den_next;
    logic [DCNT_W-1:0]          dcnt_reg, dcnt_next;
    logic                       neg_reg, neg_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic signed [CLEAN_W-1:0]  clean_reg, clean_next;
    logic                       bend_reg, bend_next;
    logic [PEAK_W-1:0]          peak_out_reg, peak_out_next;

    // datapath
    logic signed [SAMPLE_W:0]   pair_sum;
    logic signed [SAMPLE_W:0]   avg_wide;
    logic signed [SAMPLE_W-1:0] avg;
    logic signed [SAMPLE_W-1:0] chan;
    logic signed [Y_W-1:0]      y_flip;
    logic signed [CLEAN_W-1:0]  y_sat;
    logic signed [Y_W-1:0]      y_abs;
    logic [PEAK_W-1:0]          mag;
    logic [PEAK_W-1:0]          peak_upd;
    logic [CNT_W:0]             cnt_plus;
    logic [LEN_W-1:0]           len_eff;
    logic                       blk_end;
    logic                       shape_go;
    logic [ACC_W-1:0]           acc_mag;
    logic [RT_W-1:0]            rt_mag;
    logic [DVS_W:0]             rem_sh;
    logic                       fits;
    logic [DVS_W-1:0]           rem_step;
    logic [DVD_W-1:0]           num_step;
    logic signed [MEAN_W-1:0]   q_signed;
    logic signed [MEAN_W-1:0]   dc_q;
    logic signed [MEAN_W-1:0]   old_mean;

    // ring memory
    logic                       ram_wr_en;
    logic                       ram_rd_en;
    logic [MEAN_W-1:0]          ram_rd_data;

    rdcfp_ram #(
        .WIDTH (MEAN_W),
        .DEPTH (DC_BLOCKS)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ring_pos_reg),
        .wr_data (mean_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ring_pos_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        pair_sum = {left_reg[SAMPLE_W-1], left_reg} + {right_reg[SAMPLE_W-1], right_reg};
        avg_wide = (pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]}) >>> 1;
        avg      = avg_wide[SAMPLE_W-1:0];
        chan     = chsel_reg ? right_reg : left_reg;

        y_flip = (flip_reg && !phase_reg) ? -y_raw_reg : y_raw_reg;
        priority case (y_flip[Y_W-1:Y_W-2])
            2'b01:   y_sat = {1'b0, {(CLEAN_W-1){1'b1}}};
            2'b10:   y_sat = {1'b1, {(CLEAN_W-1){1'b0}}};
            default: y_sat = y_flip[CLEAN_W-1:0];
        endcase
        y_abs = y_sat[CLEAN_W-1] ? -Y_W'(y_sat) : Y_W'(y_sat);
        mag   = (y_abs[Y_W-1:PEAK_W] != '0) ? {PEAK_W{1'b1}} : y_abs[PEAK_W-1:0];
        peak_upd = (!count_reg[0] && (mag > peak_reg)) ? mag : peak_reg;

        cnt_plus = {1'b0, count_reg} + (CNT_W+1)'(1);
        if (blen_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (LEN_W'(blen_reg) > LEN_W'(MAX_BLOCK_LENGTH))
        begin
            len_eff = LEN_W'(MAX_BLOCK_LENGTH);
        end
        else
        begin
            len_eff = LEN_W'(blen_reg);
        end
        blk_end  = LEN_W'(cnt_plus) >= len_eff;
        shape_go = !out_valid_reg || out_ready;

        acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        rt_mag  = ring_total_reg[RT_W-1] ? RT_W'(-ring_total_reg) : RT_W'(ring_total_reg);

        rem_sh   = {rem_reg, num_reg[DVD_W-1]};
        fits     = rem_sh >= {1'b0, den_reg};
        rem_step = fits ? DVS_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DVS_W-1:0];
        num_step = {num_reg[DVD_W-2:0], fits};
        q_signed = neg_reg ? -signed'(num_reg[MEAN_W-1:0]) : signed'(num_reg[MEAN_W-1:0]);
        dc_q     = neg_reg ? -signed'(prod_reg[DC_SHIFT +: MEAN_W])
                           : signed'(prod_reg[DC_SHIFT +: MEAN_W]);
        old_mean = ring_valid_reg[ring_pos_reg] ? signed'(ram_rd_data) : '0;
    end

    always_comb
    begin
        state_next      = state_reg;
        blen_next       = blen_reg;
        mix_next        = mix_reg;
        chsel_next      = chsel_reg;
        flip_next       = flip_reg;
        count_next      = count_reg;
        acc_next        = acc_reg;
        ring_pos_next   = ring_pos_reg;
        ring_total_next = ring_total_reg;
        dc_next         = dc_reg;
        phase_next      = phase_reg;
        peak_next       = peak_reg;
        ring_valid_next = ring_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        left_next       = left_reg;
        right_next      = right_reg;
        y_raw_next      = y_raw_reg;
        mean_next       = mean_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        dcnt_next       = dcnt_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        clean_next      = clean_reg;
        bend_next       = bend_reg;
        peak_out_next   = peak_out_reg;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BLOCK_LENGTH:   blen_next  = cfg_data[BLEN_W-1:0];
                REG_MIX_ENABLE:     mix_next   = cfg_data[0];
                REG_CHANNEL_SELECT: chsel_next = cfg_data[0];
                REG_FLIP_ENABLE:    flip_next  = cfg_data[0];
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    left_next  = left_sample;
                    right_next = right_sample;
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                if (mix_reg)
                begin
                    acc_next   = acc_reg + ACC_W'(avg);
                    y_raw_next = Y_W'(signed'({avg, {FRAC_W{1'b0}}})) - Y_W'(dc_reg);
                end
                else
                begin
                    y_raw_next = Y_W'(signed'({chan, {FRAC_W{1'b0}}}));
                end
                state_next = S_SHAPE;
            end
            S_SHAPE:
            begin
                if (shape_go)
                begin
                    out_valid_next = 1'b1;
                    clean_next     = y_sat;
                    bend_next      = blk_end;
                    peak_out_next  = blk_end ? peak_upd : '0;
                    if (flip_reg)
                    begin
                        phase_next = !phase_reg;
                    end
                    if (blk_end)
                    begin
                        // start block-mean division; fetch the slot it replaces
                        num_next   = DVD_W'({acc_mag, {FRAC_W{1'b0}}});
                        rem_next   = '0;
                        den_next   = DVS_W'(cnt_plus);
                        neg_next   = acc_reg[ACC_W-1];
                        dcnt_next  = DCNT_W'(DVD_W);
                        ram_rd_en  = 1'b1;
                        acc_next   = '0;
                        peak_next  = '0;
                        count_next = '0;
                        state_next = S_DIVM;
                    end
                    else
                    begin
                        peak_next  = peak_upd;
                        count_next = count_reg + CNT_W'(1);
                        state_next = S_IDLE;
                    end
                end
            end
            S_DIVM:
            begin
                num_next  = num_step;
                rem_next  = rem_step;
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(1))
                begin
                    state_next = S_RSUB;
                end
            end
            S_RSUB:
            begin
                ring_total_next = ring_total_reg - RT_W'(old_mean);
                mean_next       = q_signed;
                state_next      = S_RADD;
            end
            S_RADD:
            begin
                ring_total_next              = ring_total_reg + RT_W'(mean_reg);
                ram_wr_en                    = 1'b1;
                ring_valid_next[ring_pos_reg] = 1'b1;
                ring_pos_next = (ring_pos_reg == RP_W'(DC_BLOCKS - 1)) ? '0
                              : ring_pos_reg + RP_W'(1);
                state_next    = S_DCLD;
            end
            S_DCLD:
            begin
                prod_next  = PROD_W'(rt_mag) * PROD_W'(DC_RECIP);
                neg_next   = ring_total_reg[RT_W-1];
                state_next = S_DCSET;
            end
            S_DCSET:
            begin
                dc_next    = dc_q;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            blen_reg       <= BLEN_RESET;
            mix_reg        <= 1'b1;
            chsel_reg      <= 1'b0;
            flip_reg       <= 1'b0;
            count_reg      <= '0;
            acc_reg        <= '0;
            ring_pos_reg   <= '0;
            ring_total_reg <= '0;
            dc_reg         <= '0;
            phase_reg      <= 1'b0;
            peak_reg       <= '0;
            ring_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            blen_reg       <= blen_next;
            mix_reg        <= mix_next;
            chsel_reg      <= chsel_next;
            flip_reg       <= flip_next;
            count_reg      <= count_next;
            acc_reg        <= acc_next;
            ring_pos_reg   <= ring_pos_next;
            ring_total_reg <= ring_total_next;
            dc_reg         <= dc_next;
            phase_reg      <= phase_next;
            peak_reg       <= peak_next;
            ring_valid_reg <= ring_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg     <= left_next;
        right_reg    <= right_next;
        y_raw_reg    <= y_raw_next;
        mean_reg     <= mean_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        dcnt_reg     <= dcnt_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
        clean_reg    <= clean_next;
        bend_reg     <= bend_next;
        peak_out_reg <= peak_out_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign clean_sample = clean_reg;
    assign block_end    = bend_reg;
    assign peak_level   = peak_out_reg;

    `RDFP_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "accepted beat while busy")
    `RDFP_ASSERT_SAME(a_peak_at_end_only, out_valid && !block_end, peak_level == '0, "peak off block end")
    `RDFP_ASSERT_SAME(a_ring_pos_range, 1'b1, ring_pos_reg <= RP_W'(DC_BLOCKS - 1), "ring slot out of range")
    `RDFP_ASSERT_SAME(a_div_den_nonzero, state_reg == S_DIVM, den_reg != '0, "divide by zero")

endmodule

@@ rtl/core/rdcfp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rdcfp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
